// ----- hdl/ssca_pkg.sv -----
// shared constants, types and state codes for the slab size class allocator
// no dependencies; imported by the allocator and its testbench
`timescale 1ns / 1ps
`default_nettype none
package ssca_pkg;

  localparam int NUM_CLASSES     = 7;
  localparam int PAGES_PER_CLASS = 16;
  localparam int PAGE_BYTES      = 4096;
  localparam int MIN_BLOCK_BYTES = 32;
  localparam int HEADER_BYTES    = 8;

  localparam int TOTAL_PAGES     = NUM_CLASSES * PAGES_PER_CLASS;
  localparam int BLOCKS_PER_PAGE = PAGE_BYTES / MIN_BLOCK_BYTES;
  localparam int TOTAL_BLOCKS    = TOTAL_PAGES * BLOCKS_PER_PAGE;

  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int PG_W   = $clog2(PAGES_PER_CLASS);
  localparam int CNT_W  = $clog2(PAGES_PER_CLASS + 1);
  localparam int GPG_W  = CLS_W + PG_W;
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int LNK_W  = OFF_W + 1;
  localparam int BIX_W  = $clog2(BLOCKS_PER_PAGE);
  localparam int SLOT_W = GPG_W + BIX_W;
  localparam int MIN_SH = $clog2(MIN_BLOCK_BYTES);
  localparam int LEN_W  = 16;
  localparam int ADDR_W = 19;
  localparam int ST_W   = 3;
  localparam int NEED_W = LEN_W + 1 - MIN_SH;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_ZERO    = 3'd1,
    STAT_BIG     = 3'd2,
    STAT_OOM     = 3'd3,
    STAT_BADFREE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_HEAD,
    S_LINK,
    S_UPD,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/ssca_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ssca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/slab_size_class_allocator.sv -----
// slab allocator with power-of-two size classes, alloc and free requests
// depends on ssca_pkg and ssca_ram (page head memory and block link memory)
// sequence: alloc runs decode, page scan, head read, link read and update states
//   (zero length / too large end at decode, out of memory at scan), free runs decode,
//   head read and link write (null or bad free end at decode); one request at a time,
//   paced by these steps through the two memories, and a stalled out holds the done state
// reset: synchronous active low; afterwards a clearing pass writes all 14336
//   entries of the block link memory to zero, in_tready stays low during it
`timescale 1ns / 1ps
`default_nettype none
module slab_size_class_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [15:0] req_length, [34:16] req_address, zero pad
  input  wire logic        in_tuser,   // req_type: 0 allocate, 1 free
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [18:0] result_address, [21:19] result_status
);
  import ssca_pkg::*;

  // control state
  state_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]      clr_idx_r, clr_idx_nxt;

  // per-page full flags and per-class counters live in flops
  logic [TOTAL_PAGES-1:0] full_r, full_nxt;
  logic [CNT_W-1:0]       opened_r [NUM_CLASSES];
  logic [CNT_W-1:0]       opened_nxt [NUM_CLASSES];
  logic [PG_W-1:0]        lowest_r [NUM_CLASSES];
  logic [PG_W-1:0]        lowest_nxt [NUM_CLASSES];

  // request being worked on
  logic                   type_r, type_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  logic [CLS_W-1:0]       cls_r, cls_nxt;
  logic [PG_W-1:0]        page_r, page_nxt;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic                   new_page_r, new_page_nxt;
  logic [ADDR_W-1:0]      res_addr_r, res_addr_nxt;
  status_t                res_stat_r, res_stat_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  status_t                out_stat_r, out_stat_nxt;

  // memory ports
  logic                   head_we;
  logic [GPG_W-1:0]       head_waddr;
  logic [OFF_W-1:0]       head_wdata;
  logic [OFF_W-1:0]       head_rdata;
  logic                   link_we;
  logic [SLOT_W-1:0]      link_waddr;
  logic [LNK_W:0]         link_wdata;   // {written, link}
  logic [SLOT_W-1:0]      link_raddr;
  logic [LNK_W:0]         link_rdata;

  // decode helpers
  logic [LEN_W:0]         len_sum;
  logic [NEED_W-1:0]      need_units;
  logic                   cls_fit;
  logic [CLS_W-1:0]       cls_sel;
  logic [ADDR_W-1:0]      fr_base;
  logic [GPG_W-1:0]       fr_gpage;
  logic [OFF_W-1:0]       fr_off;
  logic [CLS_W-1:0]       fr_cls;
  logic [PG_W-1:0]        fr_page;
  logic [CNT_W-1:0]       fr_opened;
  logic [OFF_W-1:0]       fr_mask;
  logic                   scan_hit;
  logic [PG_W-1:0]        scan_page;
  logic [LNK_W-1:0]       bsize;
  logic [LNK_W-1:0]       pop_next;
  logic [OFF_W-1:0]       alloc_off;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_stat_r, out_addr_r};

  // page head offsets, one entry per page
  ssca_ram #(.WIDTH(OFF_W), .DEPTH(TOTAL_PAGES)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr ({cls_r, page_r}),
    .rdata (head_rdata)
  );

  // block free-list links with written flag, one entry per minimum block
  ssca_ram #(.WIDTH(LNK_W + 1), .DEPTH(TOTAL_BLOCKS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // alloc size: header added, rounded up to minimum blocks, smallest fitting class
  always_comb begin
    len_sum    = (LEN_W+1)'(len_r) + (LEN_W+1)'(HEADER_BYTES + MIN_BLOCK_BYTES - 1);
    need_units = NEED_W'(len_sum >> MIN_SH);
    cls_fit    = 1'b0;
    cls_sel    = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if ((NEED_W'(1) << c) >= need_units &&
          (MIN_BLOCK_BYTES << c) <= PAGE_BYTES) begin
        cls_fit = 1'b1;
        cls_sel = CLS_W'(c);
      end
    end
  end

  // free address split into class, page and offset
  always_comb begin
    fr_base   = addr_r - ADDR_W'(HEADER_BYTES);
    fr_gpage  = fr_base[OFF_W +: GPG_W];
    fr_off    = fr_base[OFF_W-1:0];
    fr_cls    = fr_gpage[PG_W +: CLS_W];
    fr_page   = fr_gpage[PG_W-1:0];
    fr_opened = (fr_gpage < GPG_W'(TOTAL_PAGES)) ? opened_r[fr_cls] : '0;
    fr_mask   = (OFF_W'(MIN_BLOCK_BYTES) << fr_cls) - OFF_W'(1);
  end

  // first page at or above the lowest-free mark that is unopened or has room
  always_comb begin
    scan_hit  = 1'b0;
    scan_page = '0;
    for (int p = PAGES_PER_CLASS - 1; p >= 0; p--) begin
      if (PG_W'(p) >= lowest_r[cls_r] &&
          ((CNT_W'(p) >= opened_r[cls_r]) || !full_r[{cls_r, PG_W'(p)}])) begin
        scan_hit  = 1'b1;
        scan_page = PG_W'(p);
      end
    end
  end

  // pop arithmetic
  assign bsize     = LNK_W'(MIN_BLOCK_BYTES) << cls_r;
  assign alloc_off = new_page_r ? '0 : head_rdata;
  assign pop_next  = link_rdata[LNK_W] ? link_rdata[LNK_W-1:0]
                                       : (LNK_W'(off_r) + bsize);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        opened_r[c] <= '0;
        lowest_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
      opened_r    <= opened_nxt;
      lowest_r    <= lowest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r     <= type_nxt;
    len_r      <= len_nxt;
    addr_r     <= addr_nxt;
    cls_r      <= cls_nxt;
    page_r     <= page_nxt;
    off_r      <= off_nxt;
    new_page_r <= new_page_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    full_nxt      = full_r;
    opened_nxt    = opened_r;
    lowest_nxt    = lowest_r;
    type_nxt      = type_r;
    len_nxt       = len_r;
    addr_nxt      = addr_r;
    cls_nxt       = cls_r;
    page_nxt      = page_r;
    off_nxt       = off_r;
    new_page_nxt  = new_page_r;
    res_addr_nxt  = res_addr_r;
    res_stat_nxt  = res_stat_r;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    head_we       = 1'b0;
    head_waddr    = {cls_r, page_r};
    head_wdata    = off_r;
    link_we       = 1'b0;
    link_waddr    = {cls_r, page_r, off_r[OFF_W-1 -: BIX_W]};
    link_wdata    = '0;
    link_raddr    = {cls_r, page_r, alloc_off[OFF_W-1 -: BIX_W]};

    case (state_r)
      S_CLEAR: begin
        // zero every link entry so all read as unwritten
        link_we     = 1'b1;
        link_waddr  = clr_idx_r;
        link_wdata  = '0;
        clr_idx_nxt = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r == SLOT_W'(TOTAL_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          type_nxt  = in_tuser;
          len_nxt   = in_tdata[LEN_W-1:0];
          addr_nxt  = in_tdata[LEN_W +: ADDR_W];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_addr_nxt = '0;
        res_stat_nxt = STAT_OK;
        if (type_r == REQ_ALLOC) begin
          cls_nxt = cls_sel;
          if (len_r == '0) begin
            res_stat_nxt = STAT_ZERO;
            state_nxt    = S_DONE;
          end else if (!cls_fit) begin
            res_stat_nxt = STAT_BIG;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else begin
          cls_nxt  = fr_cls;
          page_nxt = fr_page;
          off_nxt  = fr_off;
          if (addr_r == '0) begin
            state_nxt = S_DONE;          // null free
          end else if (addr_r < ADDR_W'(HEADER_BYTES) ||
                       fr_gpage >= GPG_W'(TOTAL_PAGES) ||
                       CNT_W'(fr_page) >= fr_opened ||
                       (fr_off & fr_mask) != '0) begin
            res_stat_nxt = STAT_BADFREE;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_SCAN: begin
        page_nxt     = scan_page;
        new_page_nxt = CNT_W'(scan_page) >= opened_r[cls_r];
        if (scan_hit) begin
          state_nxt = S_HEAD;
        end else begin
          res_stat_nxt = STAT_OOM;
          state_nxt    = S_DONE;
        end
      end
      S_HEAD: begin
        // head ram read of the selected page in flight
        state_nxt = S_LINK;
      end
      S_LINK: begin
        if (type_r == REQ_ALLOC) begin
          off_nxt   = alloc_off;
          state_nxt = S_UPD;
        end else begin
          // push freed block on the page list
          link_we    = 1'b1;
          link_wdata = {1'b1, full_r[{cls_r, page_r}] ? LNK_W'(PAGE_BYTES)
                                                      : LNK_W'(head_rdata)};
          head_we    = 1'b1;
          head_wdata = off_r;
          full_nxt[{cls_r, page_r}] = 1'b0;
          if (page_r < lowest_r[cls_r]) begin
            lowest_nxt[cls_r] = page_r;
          end
          state_nxt = S_DONE;
        end
      end
      S_UPD: begin
        // pop: advance head or mark page full
        if (pop_next[OFF_W]) begin
          full_nxt[{cls_r, page_r}] = 1'b1;
        end else begin
          full_nxt[{cls_r, page_r}] = 1'b0;
          head_we    = 1'b1;
          head_wdata = pop_next[OFF_W-1:0];
        end
        if (new_page_r) begin
          opened_nxt[cls_r] = CNT_W'(page_r) + CNT_W'(1);
        end
        lowest_nxt[cls_r] = page_r;
        res_addr_nxt = {cls_r, page_r, off_r} + ADDR_W'(HEADER_BYTES);
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- verif/tb_slab_size_class_allocator.sv -----
// self-checking testbench for slab_size_class_allocator: allocate and free requests
// depends on ssca_pkg and the allocator rtl; predicts every result word in the bench
`timescale 1ns / 1ps
module tb_slab_size_class_allocator;
  import ssca_pkg::*;

  localparam int WATCH_LIMIT = 40000;

  typedef struct packed {
    logic        kind;
    logic [15:0] length;
    logic [18:0] addr;
  } req_t;

  typedef struct packed {
    logic [18:0] addr;
    status_t     status;
  } rsp_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;

  slab_size_class_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // allocator shadow state
  int unsigned page_head[TOTAL_PAGES];
  bit          page_full[TOTAL_PAGES];
  int unsigned cls_opened[NUM_CLASSES];
  int unsigned cls_low[NUM_CLASSES];
  int unsigned blk_link[TOTAL_BLOCKS];
  bit          blk_linked[TOTAL_BLOCKS];

  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  logic [18:0] live_addrs[$];   // addresses handed out and not yet freed
  int          errors = 0;
  int          n_alloc = 0, n_free = 0, n_stat[5];
  bit          hold_send = 0;
  bit          quiet = 0;       // no random idling while set
  int          watch = 0;

  // work out the result of one request and update the shadow state
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int unsigned need, c, bsize, g, off, nxt, base, p, slot;
    res.addr = '0;
    res.status = STAT_OK;
    if (r.kind == REQ_ALLOC) begin
      if (r.length == 0) begin
        res.status = STAT_ZERO;
        return res;
      end
      need = (r.length + HEADER_BYTES + MIN_BLOCK_BYTES - 1) / MIN_BLOCK_BYTES * MIN_BLOCK_BYTES;
      c = 0;
      while (c < NUM_CLASSES && (MIN_BLOCK_BYTES << c) < need) c++;
      if (c >= NUM_CLASSES || (MIN_BLOCK_BYTES << c) > PAGE_BYTES) begin
        res.status = STAT_BIG;
        return res;
      end
      bsize = MIN_BLOCK_BYTES << c;
      for (p = cls_low[c]; p < PAGES_PER_CLASS; p++) begin
        g = c * PAGES_PER_CLASS + p;
        if (p >= cls_opened[c]) begin
          cls_opened[c] = p + 1;
          page_head[g] = 0;
          page_full[g] = 0;
        end
        if (!page_full[g]) begin
          off = page_head[g] % PAGE_BYTES;
          slot = g * BLOCKS_PER_PAGE + off / MIN_BLOCK_BYTES;
          nxt = blk_linked[slot] ? blk_link[slot] : off + bsize;
          if (nxt >= PAGE_BYTES) page_full[g] = 1;
          else page_head[g] = nxt;
          cls_low[c] = p;
          res.addr = 19'(g * PAGE_BYTES + off + HEADER_BYTES);
          return res;
        end
      end
      res.status = STAT_OOM;
      return res;
    end
    if (r.addr == 0) return res;
    if (r.addr < HEADER_BYTES) begin
      res.status = STAT_BADFREE;
      return res;
    end
    base = r.addr - HEADER_BYTES;
    g = base / PAGE_BYTES;
    off = base % PAGE_BYTES;
    if (g >= TOTAL_PAGES) begin
      res.status = STAT_BADFREE;
      return res;
    end
    c = g / PAGES_PER_CLASS;
    p = g % PAGES_PER_CLASS;
    bsize = MIN_BLOCK_BYTES << c;
    if (p >= cls_opened[c] || off % bsize != 0) begin
      res.status = STAT_BADFREE;
      return res;
    end
    if (p < cls_low[c]) cls_low[c] = p;
    slot = g * BLOCKS_PER_PAGE + off / MIN_BLOCK_BYTES;
    blk_link[slot] = page_full[g] ? PAGE_BYTES : page_head[g];
    blk_linked[slot] = 1;
    page_head[g] = off;
    page_full[g] = 0;
    return res;
  endfunction

  function automatic req_t mk_alloc(int unsigned len);
    req_t r;
    r.kind = REQ_ALLOC;
    r.length = 16'(len);
    r.addr = 19'($urandom);
    return r;
  endfunction

  function automatic req_t mk_free(logic [18:0] a);
    req_t r;
    r.kind = REQ_FREE;
    r.length = 16'($urandom);
    r.addr = a;
    return r;
  endfunction

  // length mostly in small classes so pages fill and exhaust
  function automatic int unsigned rand_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return $urandom_range(1, 24);
    if (k < 70) return $urandom_range(25, 248);
    if (k < 85) return $urandom_range(249, 2040);
    if (k < 90) return $urandom_range(2041, 4088);
    if (k < 95) return $urandom_range(4089, 65535);
    return 0;
  endfunction

  // driver: words come from pending_reqs; the predictor runs at acceptance
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      expected_rsps.push_back(apply_request({in_tuser, in_tdata[15:0], in_tdata[34:16]}));
      if (in_tuser == REQ_ALLOC) n_alloc++;
      else n_free++;
    end
    if (rst_n && !(in_tvalid && !in_tready)) begin
      if (pending_reqs.size() != 0 && !hold_send && (quiet || $urandom_range(0, 99) >= 6)) begin
        req_t r;
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= r.kind;
        in_tdata  <= {5'b0, r.addr, r.length};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and result checker
  always @(posedge clk) begin
    rsp_t want;
    if (out_tvalid && out_tready) begin
      if (expected_rsps.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (out_tdata[18:0] !== want.addr) begin
          $error("result_address expected %h actual %h", want.addr, out_tdata[18:0]);
          errors++;
        end
        if (out_tdata[21:19] !== want.status) begin
          $error("result_status expected %0d actual %0d", want.status, out_tdata[21:19]);
          errors++;
        end
        if (want.status <= STAT_BADFREE) n_stat[want.status]++;
        // keep successful allocations around for later frees
        if (want.status == STAT_OK && want.addr != 0) live_addrs.push_back(want.addr);
      end
    end
    out_tready <= quiet || $urandom_range(0, 99) >= 6;
  end

  // watchdog: cycles without any accepted word, clearing pass included
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WATCH_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_rsps.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0) @(posedge clk);
  endtask

  // free a random live block, or a fake address now and then
  task automatic queue_random_free();
    int idx;
    logic [18:0] a;
    if (live_addrs.size() != 0 && $urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[idx];
      live_addrs.delete(idx);
    end else begin
      a = 19'($urandom);
    end
    pending_reqs.push_back(mk_free(a));
  endtask

  initial begin
    int i, j;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every status but out of memory, null and bad frees
    pending_reqs.push_back(mk_alloc(0));
    pending_reqs.push_back(mk_alloc(65535));
    pending_reqs.push_back(mk_alloc(4089));
    pending_reqs.push_back(mk_alloc(4088));
    pending_reqs.push_back(mk_alloc(1));
    pending_reqs.push_back(mk_alloc(24));
    pending_reqs.push_back(mk_alloc(25));
    pending_reqs.push_back(mk_alloc(2040));
    pending_reqs.push_back(mk_free(19'd0));
    pending_reqs.push_back(mk_free(19'd7));
    pending_reqs.push_back(mk_free(19'h7FFFF));
    pending_reqs.push_back(mk_free(19'd458751));
    pending_reqs.push_back(mk_free(19'd8 + 19'd16));
    pending_reqs.push_back(mk_free(19'(5 * PAGES_PER_CLASS * PAGE_BYTES + 8)));
    pending_reqs.push_back(mk_free(19'd8));
    pending_reqs.push_back(mk_free(19'd8));
    pending_reqs.push_back(mk_alloc(1));
    pending_reqs.push_back(mk_alloc(1));
    pending_reqs.push_back(mk_alloc(1));
    wait_drain();

    // 4000-byte requests exceed the largest class (2048): all 17 come back too large
    for (i = 0; i < 17; i++) pending_reqs.push_back(mk_alloc(4000));
    wait_drain();
    quiet = 1;
    // fill the 2048 class, walk its last blocks, then free/reuse with no idling
    for (i = 0; i < 33; i++) pending_reqs.push_back(mk_alloc(2000));
    wait_drain();
    for (i = 0; i < 20; i++) queue_random_free();
    for (i = 0; i < 20; i++) pending_reqs.push_back(mk_alloc(rand_len()));
    wait_drain();
    quiet = 0;

    // random phases: allocate-heavy then free-heavy bursts, with a full drain between
    for (j = 0; j < 10; j++) begin
      for (i = 0; i < 75; i++) begin
        if ($urandom_range(0, 99) < ((j % 2) ? 35 : 70)) pending_reqs.push_back(mk_alloc(rand_len()));
        else queue_random_free();
      end
      if (j == 4) begin
        // mid-burst pause until every outstanding result is back
        while (pending_reqs.size() > 40) @(posedge clk);
        hold_send = 1;
        while (expected_rsps.size() != 0 || in_tvalid) @(posedge clk);
        hold_send = 0;
      end
      wait_drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d allocates and %0d frees", n_alloc, n_free);
    $display("status ok %0d zero %0d big %0d oom %0d badfree %0d",
             n_stat[0], n_stat[1], n_stat[2], n_stat[3], n_stat[4]);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ssca_pkg.sv
hdl/ssca_ram.sv
hdl/slab_size_class_allocator.sv
verif/tb_slab_size_class_allocator.sv
